@@ src/fet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_pkg
// Types, codes and helpers shared by the float exclusion table modules.
// ----------------------------------------------------------------------------
package fet_pkg;

  localparam int MAX_FLOATS_DEF = 32;

  localparam int VAL_W      = 32;
  localparam int IN_TDATA_W = 232;
  localparam int IN_TUSER_W = 3;
  localparam int OUT_DATA_W = 141;
  localparam int OUT_TDATA_W = 144;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_TRUNC  = 3'd1,
    FN_CLEAR  = 3'd2,
    FN_NEXT   = 3'd3,
    FN_SPAN   = 3'd4
  } func_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] bottom;
    logic signed [VAL_W-1:0] edge_pos;
    logic                    is_left;
  } entry_t;

  // Running state of a table scan.
  typedef struct packed {
    logic                    hl;
    logic                    hr;
    logic signed [VAL_W-1:0] bl;
    logic signed [VAL_W-1:0] br;
    logic signed [VAL_W-1:0] sl;
    logic signed [VAL_W-1:0] sr;
  } acc_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[VAL_W] != v[VAL_W-1]) begin
      r = v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/fet_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fet_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_unit
// Shared compare unit: folds one table entry into the running scan state.
// ----------------------------------------------------------------------------
module fet_unit #(
  parameter int AW = 5
) (
  input  fet_pkg::func_t                    op,
  input  logic signed [fet_pkg::VAL_W-1:0]  y,
  input  logic signed [fet_pkg::VAL_W:0]    y_end,
  input  logic                              h_zero,
  input  fet_pkg::entry_t                   entry,
  input  logic [AW-1:0]                     idx,
  input  fet_pkg::acc_t                     acc_in,
  input  logic [AW-1:0]                     il_in,
  input  logic [AW-1:0]                     ir_in,
  output fet_pkg::acc_t                     acc_out,
  output logic [AW-1:0]                     il_out,
  output logic [AW-1:0]                     ir_out
);

  import fet_pkg::*;

  logic                    aff;
  logic                    top_ok;
  logic signed [VAL_W-1:0] cur;
  logic signed [VAL_W-1:0] cand;
  logic                    gt;
  logic                    lt;

  always_comb begin
    top_ok = h_zero ? (entry.top <= y)
                    : ($signed({entry.top[VAL_W-1], entry.top}) < y_end);
    aff    = top_ok && (y < entry.bottom);
    if (op == FN_SPAN) begin
      cur  = entry.is_left ? acc_in.sl : acc_in.sr;
      cand = entry.edge_pos;
    end else begin
      cur  = entry.is_left ? acc_in.bl : acc_in.br;
      cand = entry.bottom;
    end
    gt = cand > cur;
    lt = cand < cur;
  end

  always_comb begin
    acc_out = acc_in;
    il_out  = il_in;
    ir_out  = ir_in;
    case (op)
      FN_CLEAR: begin
        if (entry.is_left) begin
          if (!acc_in.hl || gt) begin
            acc_out.hl = 1'b1;
            acc_out.bl = entry.bottom;
            il_out     = idx;
          end
        end else begin
          if (!acc_in.hr || gt) begin
            acc_out.hr = 1'b1;
            acc_out.br = entry.bottom;
            ir_out     = idx;
          end
        end
      end
      FN_NEXT: begin
        if (aff) begin
          if (entry.is_left) begin
            acc_out.hl = 1'b1;
            acc_out.bl = entry.bottom;
          end else begin
            acc_out.hr = 1'b1;
            acc_out.br = entry.bottom;
          end
        end
      end
      FN_SPAN: begin
        if (aff) begin
          if (entry.is_left && gt) begin
            acc_out.sl = entry.edge_pos;
          end
          if (!entry.is_left && lt) begin
            acc_out.sr = entry.edge_pos;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/float_exclusion_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_exclusion_table
// Ordered table of floats with append, truncate and band queries.
// ----------------------------------------------------------------------------
// Usage: one operation enters on the s_ channel per transfer (s_tuser holds
// the operation code) and yields exactly one result transfer on m_.
// Append and truncate take effect in the accept cycle; their result is
// registered in the final step. A query walks the n held entries through the
// shared compare unit, one entry per cycle read from the table RAM, then
// passes through the DRAIN, FIN1 and FIN2 steps (only FIN1 and FIN2 when the
// table is empty). s_tready is high only while the sequencer is idle, so no
// new operation is taken until the previous one has left the last step.
// The result sits in an output register; the next operation is accepted and
// worked on while it waits, and is held in the last step until m_tready
// frees the register. Reset empties the table, zeroes the last appended top
// and drops m_tvalid; table contents need no clearing.
// ----------------------------------------------------------------------------
module float_exclusion_table #(
  parameter int MAX_FLOATS = fet_pkg::MAX_FLOATS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // float_top, float_bottom, float_edge, float_is_left, keep_count,
  // y_position, band_height, clear_mode, left_limit, right_limit
  input  logic [fet_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [fet_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // distance, span_left, span_right, found_valid, found_index, float_count,
  // last_top, status, zero fill
  output logic [fet_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import fet_pkg::*;

  localparam int AW = $clog2(MAX_FLOATS);
  localparam int CW = $clog2(MAX_FLOATS + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FIN1  = 5'b01000,
    ST_FIN2  = 5'b10000
  } state_t;

  logic signed [VAL_W-1:0] in_top;
  logic signed [VAL_W-1:0] in_bottom;
  logic signed [VAL_W-1:0] in_edge;
  logic                    in_is_left;
  logic [5:0]              in_keep;
  logic signed [VAL_W-1:0] in_y;
  logic [VAL_W-2:0]        in_h;
  logic [1:0]              in_mode;
  logic signed [VAL_W-1:0] in_left;
  logic signed [VAL_W-1:0] in_right;
  func_t                   in_func;

  state_t                  state;
  func_t                   op;
  logic signed [VAL_W-1:0] y;
  logic signed [VAL_W:0]   y_end;
  logic                    h_zero;
  logic [1:0]              mode;
  logic [CW-1:0]           count;
  logic signed [VAL_W-1:0] last_top;
  logic                    status;
  logic [AW-1:0]           addr;
  logic                    proc_valid;
  logic [AW-1:0]           proc_idx;
  acc_t                    acc;
  logic [AW-1:0]           il;
  logic [AW-1:0]           ir;
  acc_t                    acc_next;
  logic [AW-1:0]           il_next;
  logic [AW-1:0]           ir_next;
  logic signed [VAL_W-1:0] sel_bottom;
  logic                    sel_valid;
  logic [AW-1:0]           sel_idx;

  logic                    accept;
  logic                    full;
  logic                    ram_we;
  entry_t                  wr_entry;
  entry_t                  rd_entry;
  logic                    is_query;
  logic                    hlm;
  logic                    hrm;
  logic                    blt;
  logic                    use_l;

  logic signed [VAL_W-1:0] distance;
  logic signed [VAL_W-1:0] span_left;
  logic signed [VAL_W-1:0] span_right;
  logic                    found_valid;
  logic [4:0]              found_index;
  logic [5:0]              float_count;
  logic signed [VAL_W-1:0] out_last_top;
  logic                    out_status;

  assign in_top     = s_tdata[31:0];
  assign in_bottom  = s_tdata[63:32];
  assign in_edge    = s_tdata[95:64];
  assign in_is_left = s_tdata[96];
  assign in_keep    = s_tdata[102:97];
  assign in_y       = s_tdata[134:103];
  assign in_h       = s_tdata[165:135];
  assign in_mode    = s_tdata[167:166];
  assign in_left    = s_tdata[199:168];
  assign in_right   = s_tdata[231:200];
  assign in_func    = func_t'(s_tuser);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(MAX_FLOATS));
  assign ram_we   = accept && (in_func == FN_APPEND) && !full;
  assign is_query = (in_func == FN_CLEAR) || (in_func == FN_NEXT) || (in_func == FN_SPAN);

  assign wr_entry.top      = in_top;
  assign wr_entry.bottom   = in_bottom;
  assign wr_entry.edge_pos = in_edge;
  assign wr_entry.is_left  = in_is_left;

  fet_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_FLOATS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (addr),
    .rdata (rd_entry)
  );

  fet_unit #(
    .AW (AW)
  ) u_unit (
    .op      (op),
    .y       (y),
    .y_end   (y_end),
    .h_zero  (h_zero),
    .entry   (rd_entry),
    .idx     (proc_idx),
    .acc_in  (acc),
    .il_in   (il),
    .ir_in   (ir),
    .acc_out (acc_next),
    .il_out  (il_next),
    .ir_out  (ir_next)
  );

  always_comb begin
    hlm = acc.hl && mode[0];
    hrm = acc.hr && mode[1];
    blt = acc.bl < acc.br;
    if (op == FN_CLEAR) begin
      use_l = hlm && (!hrm || !blt);
    end else begin
      use_l = acc.hl && (!acc.hr || blt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      last_top   <= '0;
      proc_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      proc_valid <= (state == ST_SCAN);
      if ((state == ST_FIN2) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (ram_we) begin
              count    <= count + CW'(1);
              last_top <= in_top;
            end
            if ((in_func == FN_TRUNC) && (XW'(in_keep) < XW'(count))) begin
              count <= CW'(in_keep);
            end
            if (!is_query) begin
              state <= ST_FIN2;
            end else if (count == '0) begin
              state <= ST_FIN1;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (CW'(addr) == count - CW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN1;
        end
        ST_FIN1: begin
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= addr;
    if (state == ST_SCAN) begin
      addr <= addr + AW'(1);
    end
    if (proc_valid) begin
      acc <= acc_next;
      il  <= il_next;
      ir  <= ir_next;
    end
    if (accept) begin
      op      <= in_func;
      y       <= in_y;
      y_end   <= $signed({in_y[VAL_W-1], in_y}) + $signed({2'b00, in_h});
      h_zero  <= (in_h == '0);
      mode    <= in_mode;
      status  <= (in_func == FN_APPEND) && full;
      addr    <= '0;
      acc.hl  <= 1'b0;
      acc.hr  <= 1'b0;
      acc.bl  <= '0;
      acc.br  <= '0;
      acc.sl  <= in_left;
      acc.sr  <= in_right;
      il      <= '0;
      ir      <= '0;
      sel_valid <= 1'b0;
    end
    if (state == ST_FIN1) begin
      sel_bottom <= use_l ? acc.bl : acc.br;
      sel_idx    <= use_l ? il : ir;
      if (op == FN_CLEAR) begin
        sel_valid <= hlm || hrm;
      end else begin
        sel_valid <= acc.hl || acc.hr;
      end
    end
    if ((state == ST_FIN2) && (!m_tvalid || m_tready)) begin
      float_count  <= 6'(count);
      out_last_top <= last_top;
      out_status   <= status;
      if (((op == FN_CLEAR) || (op == FN_NEXT)) && sel_valid) begin
        distance <= sat32($signed({sel_bottom[VAL_W-1], sel_bottom})
                          - $signed({y[VAL_W-1], y}));
      end else begin
        distance <= '0;
      end
      if ((op == FN_CLEAR) && sel_valid) begin
        found_valid <= 1'b1;
        found_index <= 5'(sel_idx);
      end else begin
        found_valid <= 1'b0;
        found_index <= '0;
      end
      if (op == FN_SPAN) begin
        span_left  <= acc.sl;
        span_right <= acc.sr;
      end else begin
        span_left  <= '0;
        span_right <= '0;
      end
    end
  end

  assign m_tdata = {3'b000, out_status, out_last_top, float_count, found_index,
                    found_valid, span_right, span_left, distance};

`ifndef SYNTH
  a_full_append_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_func == FN_APPEND) && full) |=> (count == $past(count)))
    else $error("append into a full table changed the count");

  a_trunc_never_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_func == FN_TRUNC)) |=> (count <= $past(count)))
    else $error("truncate grew the table");

  a_scan_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(addr) < count))
    else $error("scan address beyond held entries");

  a_proc_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> ((state == ST_SCAN) || (state == ST_DRAIN)))
    else $error("entry folded outside the scan");

  a_query_holds_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_DRAIN) || (state == ST_FIN1))
      |=> (count == $past(count)))
    else $error("count changed during a query");
`endif

endmodule
